FILE: hdl/receive_match_queues_macros.svh
// ----------------------------------------------------------------------------
// receive_match_queues assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RECEIVE_MATCH_QUEUES_MACROS_SVH
`define RECEIVE_MATCH_QUEUES_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RMQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("receive_match_queues check failed");
// next-cycle implication
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("receive_match_queues check failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and codes of the receive match queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

  // request kind
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_POST   = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_MATCHED    = 2'd0;
  localparam logic [1:0] STAT_POSTED     = 2'd1;
  localparam logic [1:0] STAT_UNEXPECTED = 2'd2;
  localparam logic [1:0] STAT_DROPPED    = 2'd3;

  localparam int HANDLE_W = 16;
  localparam int SRC_W    = 16;
  localparam int LEN_W    = 16;
  localparam int MSG_W    = 16;
  localparam int BUF_W    = 32;
  localparam int LEFT_W   = 5;

  // payload stored next to the key in each queue cell
  localparam int POSTED_DATA_W = HANDLE_W + BUF_W;
  localparam int UNEXP_DATA_W  = LEN_W + MSG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } rmq_state_t;

  // update command to a queue row
  typedef struct packed {
    logic commit;
    logic remove;
    logic append;
  } rmq_qop_t;

  // search status back from a queue row
  typedef struct packed {
    logic hit;
    logic full;
  } rmq_qstat_t;

endpackage

FILE: hdl/rmq_in_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if
// Request channel: message arrivals and receive posts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rmq_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] src;
  logic [15:0] msg_length;
  logic [15:0] msg_ref;
  logic [31:0] buf_ref;

  modport source (output valid, func, src, msg_length, msg_ref, buf_ref, input ready);
  modport sink   (input valid, func, src, msg_length, msg_ref, buf_ref, output ready);
endinterface

FILE: hdl/rmq_out_if.sv
// ----------------------------------------------------------------------------
// rmq_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rmq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] handle;
  logic [15:0] match_src;
  logic [31:0] match_buf;
  logic [15:0] match_msg;
  logic [15:0] match_length;
  logic [4:0]  posted_left;

  modport source (output valid, status, handle, match_src, match_buf, match_msg,
                  match_length, posted_left, input ready);
  modport sink   (input valid, status, handle, match_src, match_buf, match_msg,
                  match_length, posted_left, output ready);
endinterface

FILE: hdl/rmq_cell.sv
// ----------------------------------------------------------------------------
// rmq_cell
// One queue slot: key compare, first-hit chain and shift/append update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_cell import rmq_pkg::*; #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  rmq_qop_t          op,
  input  logic [SRC_W-1:0]  key_src,
  input  logic              prev_valid,
  input  logic              hit_in,
  input  logic [DATA_W-1:0] found_in,
  input  logic              next_valid,
  input  logic [SRC_W-1:0]  next_src,
  input  logic [DATA_W-1:0] next_data,
  input  logic [SRC_W-1:0]  new_src,
  input  logic [DATA_W-1:0] new_data,
  output logic              valid,
  output logic              hit_out,
  output logic [DATA_W-1:0] found_out,
  output logic [SRC_W-1:0]  cur_src,
  output logic [DATA_W-1:0] cur_data
);

  logic [SRC_W-1:0]  src;
  logic [DATA_W-1:0] data;
  logic              match_q;
  logic              take_next;
  logic              take_new;

  assign cur_src  = src;
  assign cur_data = data;

  assign hit_out   = hit_in | match_q;
  // older cell already matched: pass its data through
  assign found_out = hit_in ? found_in : (match_q ? data : '0);

  // at or after the removed slot every cell shifts toward the head
  assign take_next = op.commit && op.remove && hit_out;
  // first free slot behind the valid run takes the new entry
  assign take_new  = op.commit && op.append && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      match_q <= valid && (src == key_src);
      if (take_next) begin
        valid <= next_valid;
      end else if (take_new) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_next) begin
      src  <= next_src;
      data <= next_data;
    end else if (take_new) begin
      src  <= new_src;
      data <= new_data;
    end
  end

endmodule

FILE: hdl/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue
// Ordered row of cells with fill count; oldest entry sits in cell 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "receive_match_queues_macros.svh"

module rmq_queue import rmq_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int CNT_W  = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  rmq_qop_t          op,
  input  logic [SRC_W-1:0]  key_src,
  input  logic [DATA_W-1:0] new_data,
  output rmq_qstat_t        stat,
  output logic [DATA_W-1:0] found_data,
  output logic [CNT_W-1:0]  count_next
);

  logic [CNT_W-1:0]  count;
  logic [DEPTH-1:0]  valid_vec;
  logic [DEPTH:0]    hit_chain;
  logic [DATA_W-1:0] found_chain [DEPTH+1];
  logic [SRC_W-1:0]  src_vec     [DEPTH];
  logic [DATA_W-1:0] data_vec    [DEPTH];

  assign hit_chain[0]   = 1'b0;
  assign found_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_valid;
    logic              next_valid;
    logic [SRC_W-1:0]  next_src;
    logic [DATA_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_src   = '0;
      assign next_data  = '0;
    end else begin : g_link
      assign next_valid = valid_vec[i+1];
      assign next_src   = src_vec[i+1];
      assign next_data  = data_vec[i+1];
    end

    rmq_cell #(.DATA_W(DATA_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .key_src    (key_src),
      .prev_valid (prev_valid),
      .hit_in     (hit_chain[i]),
      .found_in   (found_chain[i]),
      .next_valid (next_valid),
      .next_src   (next_src),
      .next_data  (next_data),
      .new_src    (key_src),
      .new_data   (new_data),
      .valid      (valid_vec[i]),
      .hit_out    (hit_chain[i+1]),
      .found_out  (found_chain[i+1]),
      .cur_src    (src_vec[i]),
      .cur_data   (data_vec[i])
    );
  end

  assign stat.hit   = hit_chain[DEPTH];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign found_data = found_chain[DEPTH];

  always_comb begin
    count_next = count;
    if (op.commit && op.remove && stat.hit) begin
      count_next = count - CNT_W'(1);
    end else if (op.commit && op.append && !stat.full) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `RMQ_ASSERT_IMPL(a_count_tracks_valid, clk, rst, 1'b1, $countones(valid_vec) == 32'(count))
  `RMQ_ASSERT_NEXT(a_full_stays_full, clk, rst, op.commit && op.append && stat.full, count == CNT_W'(DEPTH))
  `RMQ_ASSERT_IMPL(a_hit_needs_entry, clk, rst, op.commit && stat.hit, count != '0)

endmodule

FILE: hdl/receive_match_queues.sv
// Receive match queues: each request transaction is a message arrival or a
// receive post and yields exactly one result transaction. An arrival is
// matched against posted receives, a post against unexpected messages, both
// oldest entry first by source; a miss appends to the other queue, a full
// queue drops the request with status 3. Each transaction takes a compare
// state, in which every queue cell compares its stored source with the
// request, then an update state, in which the first-hit chain ripples from
// the oldest cell to the newest, the cells shift or append and the result
// loads the output register; the next request is accepted on that same edge.
// A result the sink does not take holds the block in the update cycle.
// The queues clear at once on reset through per-cell valid bits; no clearing
// pass.
// ----------------------------------------------------------------------------
// receive_match_queues
// Posted-receive and unexpected-message matching engine, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "receive_match_queues_macros.svh"

module receive_match_queues import rmq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  rmq_in_if.sink   msg_in,
  rmq_out_if.source result
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  rmq_state_t state, state_next;

  // captured request
  logic                req_func;
  logic [SRC_W-1:0]    req_src;
  logic [LEN_W-1:0]    req_len;
  logic [MSG_W-1:0]    req_msg;
  logic [BUF_W-1:0]    req_buf;
  logic [HANDLE_W-1:0] req_handle;

  logic [HANDLE_W-1:0] next_handle;

  logic accept;
  logic out_free;
  logic commit;

  rmq_qop_t   post_op, unexp_op;
  rmq_qstat_t post_stat, unexp_stat;
  logic [POSTED_DATA_W-1:0] post_found;
  logic [UNEXP_DATA_W-1:0]  unexp_found;
  logic [CntW-1:0]          post_cnt_next;
  logic [CntW-1:0]          unexp_cnt_next;

  // result being formed in the update cycle
  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SRC_W-1:0]    res_src;
  logic [BUF_W-1:0]    res_buf;
  logic [MSG_W-1:0]    res_msg;
  logic [LEN_W-1:0]    res_len;
  logic [LEFT_W-1:0]   res_left;

  assign accept   = msg_in.valid && msg_in.ready;
  assign out_free = !result.valid || result.ready;

  // ---- control FSM ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_next = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    msg_in.ready = 1'b0;
    commit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_in.ready = 1'b1;
      end
      ST_CMP: begin
        msg_in.ready = 1'b0;
      end
      ST_UPD: begin
        msg_in.ready = out_free;
        commit       = out_free;
      end
      default: begin
        msg_in.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      next_handle <= '0;
    end else begin
      state <= state_next;
      // every post consumes a handle, dropped or not
      if (accept && msg_in.func == FUNC_POST) begin
        next_handle <= next_handle + HANDLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= msg_in.func;
      req_src    <= msg_in.src;
      req_len    <= msg_in.msg_length;
      req_msg    <= msg_in.msg_ref;
      req_buf    <= msg_in.buf_ref;
      req_handle <= next_handle;
    end
  end

  // ---- queue commands ----
  // arrival: search posted, else queue as unexpected; post: the reverse
  always_comb begin
    post_op.commit  = commit;
    post_op.remove  = (req_func == FUNC_ARRIVE);
    post_op.append  = (req_func == FUNC_POST) && !unexp_stat.hit;
    unexp_op.commit = commit;
    unexp_op.remove = (req_func == FUNC_POST);
    unexp_op.append = (req_func == FUNC_ARRIVE) && !post_stat.hit;
  end

  rmq_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (POSTED_DATA_W),
    .CNT_W  (CntW)
  ) u_posted (
    .clk        (clk),
    .rst        (rst),
    .op         (post_op),
    .key_src    (req_src),
    .new_data   ({req_handle, req_buf}),
    .stat       (post_stat),
    .found_data (post_found),
    .count_next (post_cnt_next)
  );

  rmq_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (UNEXP_DATA_W),
    .CNT_W  (CntW)
  ) u_unexp (
    .clk        (clk),
    .rst        (rst),
    .op         (unexp_op),
    .key_src    (req_src),
    .new_data   ({req_len, req_msg}),
    .stat       (unexp_stat),
    .found_data (unexp_found),
    .count_next (unexp_cnt_next)
  );

  // ---- result assembly ----
  always_comb begin
    res_handle = '0;
    res_src    = '0;
    res_buf    = '0;
    res_msg    = '0;
    res_len    = '0;
    if (req_func == FUNC_ARRIVE) begin
      priority if (post_stat.hit) begin
        res_status = STAT_MATCHED;
        res_handle = post_found[POSTED_DATA_W-1 -: HANDLE_W];
        res_src    = req_src;
        res_buf    = post_found[BUF_W-1:0];
        res_msg    = req_msg;
        res_len    = req_len;
      end else if (unexp_stat.full) begin
        res_status = STAT_DROPPED;
      end else begin
        res_status = STAT_UNEXPECTED;
      end
    end else begin
      res_handle = req_handle;
      priority if (unexp_stat.hit) begin
        res_status = STAT_MATCHED;
        res_src    = req_src;
        res_buf    = req_buf;
        res_msg    = unexp_found[MSG_W-1:0];
        res_len    = unexp_found[UNEXP_DATA_W-1 -: LEN_W];
      end else if (post_stat.full) begin
        res_status = STAT_DROPPED;
      end else begin
        res_status = STAT_POSTED;
      end
    end
  end

  // posted count after this transaction, clipped to the field width
  assign res_left = (32'(post_cnt_next) > 32'd31) ? LEFT_W'(31) : LEFT_W'(post_cnt_next);

  // unexpected fill count only feeds its own queue
  logic unused_unexp_cnt;
  assign unused_unexp_cnt = ^unexp_cnt_next;

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.status       <= res_status;
      result.handle       <= res_handle;
      result.match_src    <= res_src;
      result.match_buf    <= res_buf;
      result.match_msg    <= res_msg;
      result.match_length <= res_len;
      result.posted_left  <= res_left ^ LEFT_W'(unused_unexp_cnt & 1'b0);
    end
  end

  `RMQ_ASSERT_NEXT(a_cmp_then_upd, clk, rst, state == ST_CMP, state == ST_UPD)
  `RMQ_ASSERT_NEXT(a_handle_steps, clk, rst, accept && msg_in.func == FUNC_POST, next_handle == HANDLE_W'($past(next_handle) + HANDLE_W'(1)))
  `RMQ_ASSERT_IMPL(a_posted_counted, clk, rst, result.valid && result.status == STAT_POSTED, result.posted_left != '0)

endmodule

FILE: tb/tb_receive_match_queues.sv
// ----------------------------------------------------------------------------
// tb_receive_match_queues
// Self-checking bench for the posted/unexpected matching engine. A queue-based
// model of both match queues and the handle counter predicts every result
// transaction; directed tests cover pairing, oldest-first order and full
// queues, then random traffic runs with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_receive_match_queues;
  import rmq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int LATENCY     = 2;
  // room for ~1100 transactions with full idling on both sides
  localparam int CYCLE_LIMIT = 100_000;
  localparam int REPORT_MAX  = 10;

  // one request transaction
  typedef struct packed {
    logic        func;
    logic [15:0] src;
    logic [15:0] msg_length;
    logic [15:0] msg_ref;
    logic [31:0] buf_ref;
  } match_req_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle;
    logic [15:0] match_src;
    logic [31:0] match_buf;
    logic [15:0] match_msg;
    logic [15:0] match_length;
    logic [4:0]  posted_left;
  } match_result_t;

  // model queue cells, oldest at index 0
  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] src;
    logic [31:0] buf_addr;
  } posted_rx_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] msg_length;
    logic [15:0] msg_ref;
  } unexp_msg_t;

  logic clk = 1'b0;
  logic rst;

  rmq_in_if  msg_in_bus ();
  rmq_out_if result_bus ();

  receive_match_queues #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .msg_in(msg_in_bus),
    .result(result_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model state: posted receives, unexpected messages, handle counter
  // ---------------------------------------------------------------------------
  posted_rx_t    posted_rx[$];
  unexp_msg_t    unexp_msgs[$];
  logic [15:0]   handle_ctr;

  match_result_t pending_results[$];

  // idling switches for the two sides, drawn anew per random phase
  bit src_idle;
  bit sink_idle;

  int fail_count;
  int report_count;
  int results_seen;
  int status_seen[4];
  int cycle_count;

  // Work out the result of one accepted request and advance the model.
  function automatic match_result_t resolve_request(input match_req_t rq);
    match_result_t r;
    int            hit_at;
    r      = '0;
    hit_at = -1;
    if (rq.func == FUNC_ARRIVE) begin
      // arrival: oldest posted receive with the same source wins
      foreach (posted_rx[i])
        if (hit_at < 0 && posted_rx[i].src == rq.src) hit_at = i;
      if (hit_at >= 0) begin
        r.status       = STAT_MATCHED;
        r.handle       = posted_rx[hit_at].handle;
        r.match_src    = rq.src;
        r.match_buf    = posted_rx[hit_at].buf_addr;
        r.match_msg    = rq.msg_ref;
        r.match_length = rq.msg_length;
        posted_rx.delete(hit_at);
      end else if (unexp_msgs.size() >= DEPTH) begin
        // dropped; handle stays zero, nothing changes
        r.status = STAT_DROPPED;
      end else begin
        unexp_msgs.insert(unexp_msgs.size(), {rq.src, rq.msg_length, rq.msg_ref});
        r.status = STAT_UNEXPECTED;
      end
    end else begin
      // every post takes a handle, even one that ends up dropped
      r.handle   = handle_ctr;
      handle_ctr = handle_ctr + 16'd1;
      foreach (unexp_msgs[i])
        if (hit_at < 0 && unexp_msgs[i].src == rq.src) hit_at = i;
      if (hit_at >= 0) begin
        r.status       = STAT_MATCHED;
        r.match_src    = rq.src;
        r.match_buf    = rq.buf_ref;
        r.match_msg    = unexp_msgs[hit_at].msg_ref;
        r.match_length = unexp_msgs[hit_at].msg_length;
        unexp_msgs.delete(hit_at);
      end else if (posted_rx.size() >= DEPTH) begin
        r.status = STAT_DROPPED;
      end else begin
        posted_rx.insert(posted_rx.size(), {r.handle, rq.src, rq.buf_ref});
        r.status = STAT_POSTED;
      end
    end
    r.posted_left = (posted_rx.size() > 31) ? 5'd31 : 5'(posted_rx.size());
    return r;
  endfunction

  function automatic match_req_t make_request(input logic func, input logic [15:0] src,
                                              input logic [15:0] len,
                                              input logic [15:0] slot,
                                              input logic [31:0] buf_addr);
    match_req_t rq;
    rq.func       = func;
    rq.src        = src;
    rq.msg_length = len;
    rq.msg_ref    = slot;
    rq.buf_ref    = buf_addr;
    return rq;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (report_count < REPORT_MAX) begin
      report_count++;
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: one transaction per call. Valid stays high across
  // back-to-back transactions and drops only when a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_request(input match_req_t rq);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      msg_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_in_bus.valid      <= 1'b1;
    msg_in_bus.func       <= rq.func;
    msg_in_bus.src        <= rq.src;
    msg_in_bus.msg_length <= rq.msg_length;
    msg_in_bus.msg_ref    <= rq.msg_ref;
    msg_in_bus.buf_ref    <= rq.buf_ref;
    do @(posedge clk); while (!msg_in_bus.ready);
    // accepted on this edge
    pending_results.insert(pending_results.size(), resolve_request(rq));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each transaction, then compare with the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int            stall;
    match_result_t got;
    match_result_t want;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
      got = {result_bus.status, result_bus.handle, result_bus.match_src,
             result_bus.match_buf, result_bus.match_msg, result_bus.match_length,
             result_bus.posted_left};
      results_seen++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: status=%0d handle=%h",
                               got.status, got.handle));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf({"mismatch on result %0d\n",
                                  "  exp status=%0d handle=%h src=%h buf=%h msg=%h len=%h left=%0d\n",
                                  "  got status=%0d handle=%h src=%h buf=%h msg=%h len=%h left=%0d"},
                                 results_seen,
                                 want.status, want.handle, want.match_src, want.match_buf,
                                 want.match_msg, want.match_length, want.posted_left,
                                 got.status, got.handle, got.match_src, got.match_buf,
                                 got.match_msg, got.match_length, got.posted_left));
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Arrival-then-post and post-then-arrival pairing at the field extremes.
  task automatic test_basic_pairing();
    send_request(make_request(FUNC_ARRIVE, 16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF));
    send_request(make_request(FUNC_POST,   16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF));
    send_request(make_request(FUNC_POST,   16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
    send_request(make_request(FUNC_ARRIVE, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h0000_0000));
    // different sources must not pair
    send_request(make_request(FUNC_ARRIVE, 16'h1234, 16'hA5A5, 16'h5A5A, 32'h0));
    send_request(make_request(FUNC_POST,   16'h4321, 16'h0,    16'h0,    32'h8000_0001));
    send_request(make_request(FUNC_ARRIVE, 16'h4321, 16'h00FF, 16'hFF00, 32'h0));
    send_request(make_request(FUNC_POST,   16'h1234, 16'h0,    16'h0,    32'h7FFF_FFFE));
  endtask

  // Duplicate sources: the oldest entry is matched first in both queues.
  task automatic test_oldest_first();
    send_request(make_request(FUNC_POST,   16'h0005, 16'h0, 16'h0, 32'hAAAA_0001));
    send_request(make_request(FUNC_POST,   16'h0006, 16'h0, 16'h0, 32'hBBBB_0002));
    send_request(make_request(FUNC_POST,   16'h0005, 16'h0, 16'h0, 32'hCCCC_0003));
    send_request(make_request(FUNC_ARRIVE, 16'h0005, 16'h0011, 16'h0101, 32'h0));
    send_request(make_request(FUNC_ARRIVE, 16'h0005, 16'h0022, 16'h0202, 32'h0));
    send_request(make_request(FUNC_ARRIVE, 16'h0006, 16'h0033, 16'h0303, 32'h0));
    send_request(make_request(FUNC_ARRIVE, 16'h0009, 16'h0044, 16'h0404, 32'h0));
    send_request(make_request(FUNC_ARRIVE, 16'h0009, 16'h0055, 16'h0505, 32'h0));
    send_request(make_request(FUNC_POST,   16'h0009, 16'h0, 16'h0, 32'hDDDD_0004));
    send_request(make_request(FUNC_POST,   16'h0009, 16'h0, 16'h0, 32'hEEEE_0005));
  endtask

  // Fill both queues, hit the drop path on each, then drain out of order so
  // removal from the middle of a queue gets exercised.
  task automatic test_queue_full();
    int k;
    for (int i = 0; i < DEPTH; i++)
      send_request(make_request(FUNC_ARRIVE, 16'(16'h0100 + i), 16'($urandom),
                                16'($urandom), $urandom));
    // unexpected queue full, nothing posted for this source
    send_request(make_request(FUNC_ARRIVE, 16'h01FF, 16'hFFFF, 16'hFFFF, 32'h0));
    for (int i = 0; i < DEPTH; i++)
      send_request(make_request(FUNC_POST, 16'(16'h0200 + i), 16'($urandom),
                                16'($urandom), $urandom));
    // posted queue full: dropped but still burns a handle
    send_request(make_request(FUNC_POST, 16'h02FF, 16'h0, 16'h0, 32'hFFFF_FFFF));
    // arrival that would sit in the unexpected queue is dropped too
    send_request(make_request(FUNC_ARRIVE, 16'h0100, 16'h1, 16'h1, 32'h0));
    for (int i = 0; i < DEPTH; i++) begin
      k = (i * 7) % DEPTH;
      send_request(make_request(FUNC_ARRIVE, 16'(16'h0200 + k), 16'($urandom),
                                16'($urandom), $urandom));
    end
    for (int i = 0; i < DEPTH; i++) begin
      k = (i * 5 + 3) % DEPTH;
      send_request(make_request(FUNC_POST, 16'(16'h0100 + k), 16'($urandom),
                                16'($urandom), $urandom));
    end
  endtask

  // Random phases: each picks a source window, a post/arrival mix and whether
  // each side idles. Narrow windows give many matches, the wide one fills the
  // queues with misses.
  task automatic test_random_traffic();
    logic [15:0] base;
    logic [15:0] src;
    int          spread;
    int          post_pct;
    logic        func;
    for (int phase = 0; phase < 10; phase++) begin
      base      = 16'($urandom);
      spread    = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(1, 6);
      post_pct  = $urandom_range(25, 75);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (100) begin
        src  = (spread < 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
        func = ($urandom_range(1, 100) <= post_pct) ? FUNC_POST : FUNC_ARRIVE;
        send_request(make_request(func, src, 16'($urandom), 16'($urandom), $urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    handle_ctr   = '0;
    fail_count   = 0;
    report_count = 0;
    results_seen = 0;
    status_seen  = '{default: 0};
    src_idle     = 1'b1;
    sink_idle    = 1'b1;

    rst                   <= 1'b1;
    msg_in_bus.valid      <= 1'b0;
    msg_in_bus.func       <= FUNC_ARRIVE;
    msg_in_bus.src        <= '0;
    msg_in_bus.msg_length <= '0;
    msg_in_bus.msg_ref    <= '0;
    msg_in_bus.buf_ref    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_pairing();
    test_oldest_first();
    test_queue_full();
    test_random_traffic();

    msg_in_bus.valid <= 1'b0;
    sink_idle = 1'b1;
    // guard above catches a result that never comes
    wait (pending_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d predicted results never arrived", pending_results.size()));

    $display("checked %0d results: %0d matched, %0d posted, %0d queued, %0d dropped",
             results_seen, status_seen[STAT_MATCHED], status_seen[STAT_POSTED],
             status_seen[STAT_UNEXPECTED], status_seen[STAT_DROPPED]);
    $display("pairing, oldest-first, full-queue and random phases: %0d failure(s) in %0d cycles",
             fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
